/* hdl/hrbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbp_pkg
// Shared types, constants and helper functions of the HTTP request byte
// parser: parse states, field tags, status codes and the result record.
// ----------------------------------------------------------------------------
package hrbp_pkg;

  // Width of the Content-Length accumulator; values saturate at all ones.
  localparam int LenBits = 32;
  // Characters in the header key "Content-Length"
  localparam int KeyLen = 14;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  typedef enum logic [4:0] {
    S_START, S_METHOD, S_BEFORE_URI, S_URI, S_BEFORE_PKEY, S_PKEY,
    S_BEFORE_PVAL, S_PVAL, S_BEFORE_PROTO, S_PROTO, S_BEFORE_VER, S_VER,
    S_VER_SPLIT, S_HKEY, S_HBEFORE_COLON, S_HAFTER_COLON, S_HVAL,
    S_WHEN_CR, S_CR_LF, S_CR_LF_CR, S_BODY,
    S_COMPLETE, S_INVALID, S_BAD_METHOD, S_BAD_URI, S_BAD_VERSION, S_BAD_HEADER
  } parse_state_t;

  typedef enum logic [3:0] {
    TAG_SKIP, TAG_METHOD, TAG_PATH, TAG_PKEY, TAG_PVAL, TAG_PROTO,
    TAG_VERSION, TAG_HKEY, TAG_HVAL, TAG_BODY, TAG_DELIM
  } field_tag_t;

  typedef enum logic [2:0] {
    ST_PARSING, ST_COMPLETE, ST_INVALID, ST_BAD_METHOD, ST_BAD_URI,
    ST_BAD_VERSION, ST_BAD_HEADER
  } status_t;

  // One result item as produced by the parser step
  typedef struct packed {
    logic [7:0]  byte_out;
    field_tag_t  field_tag;
    logic        token_start;
    status_t     status;
    logic [31:0] content_length;
    logic        done_res;
  } res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= ChUpA) && (c <= ChUpZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Character of "Content-Length" at a given position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Status reported for a parse state
  function automatic status_t status_of(input parse_state_t s);
    status_t st;
    case (s)
      S_COMPLETE:    st = ST_COMPLETE;
      S_INVALID:     st = ST_INVALID;
      S_BAD_METHOD:  st = ST_BAD_METHOD;
      S_BAD_URI:     st = ST_BAD_URI;
      S_BAD_VERSION: st = ST_BAD_VERSION;
      S_BAD_HEADER:  st = ST_BAD_HEADER;
      default:       st = ST_PARSING;
    endcase
    return st;
  endfunction

endpackage

/* hdl/hrbp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbp_in_if / hrbp_out_if
// Valid/ready channels of the parser: raw request bytes in, tagged bytes out.
// ----------------------------------------------------------------------------
interface hrbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface hrbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [3:0]  field_tag;
  logic        token_start;
  logic [2:0]  status;
  logic [31:0] content_length;
  logic        done_res;

  modport source (output valid, byte_out, field_tag, token_start, status,
                  content_length, done_res, input ready);
  modport sink   (input valid, byte_out, field_tag, token_start, status,
                  content_length, done_res, output ready);
endinterface

/* hdl/http_request_byte_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_byte_parser
// Byte-serial HTTP/1.1 request classifier with tagged-byte result channel.
// ----------------------------------------------------------------------------
// Each request on in_chan carries one raw request byte and produces exactly
// one result on out_chan: the byte echoed, its field tag, a token-start flag,
// the parse status, the Content-Length value seen so far and a done flag.
// One byte is taken every clock cycle while the skid register is empty;
// the state step for a byte is combinational and feeds the result register.
// A two-entry output (result register plus skid register) keeps in_chan.ready
// high while one result waits, so the input stalls only after two results are
// pending on a stalled output. Setting first_byte restarts parsing with that
// byte; once the status is final, bytes are echoed with tag skip until then.
module http_request_byte_parser (
  input  logic        clk,
  input  logic        rst_n,
  hrbp_in_if.sink     in_chan,
  hrbp_out_if.source  out_chan
);
  import hrbp_pkg::*;

  res_t step_res;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic in_fire, out_fire;

  assign in_chan.ready = !skid_valid_r;
  assign in_fire       = in_chan.valid && !skid_valid_r;
  assign out_fire      = out_valid_r && out_chan.ready;

  hrbp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_fire),
    .data_byte  (in_chan.data_byte),
    .first_byte (in_chan.first_byte),
    .last_byte  (in_chan.last_byte),
    .res        (step_res)
  );

  // Output and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_chan.ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_chan.ready) begin
        skid_r <= step_res;
      end else begin
        out_r <= step_res;
      end
    end
  end

  // Drive the result channel
  assign out_chan.valid          = out_valid_r;
  assign out_chan.byte_out       = out_r.byte_out;
  assign out_chan.field_tag      = out_r.field_tag;
  assign out_chan.token_start    = out_r.token_start;
  assign out_chan.status         = out_r.status;
  assign out_chan.content_length = out_r.content_length;
  assign out_chan.done_res       = out_r.done_res;

  // A result only waits in the skid register behind a pending output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  // A final status always reports done
  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_PARSING) |-> out_r.done_res)
    else $error("final status without done");

  // A field start is never a skipped or delimiter byte
  a_start_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.token_start) |->
      (out_r.field_tag != TAG_SKIP && out_r.field_tag != TAG_DELIM))
    else $error("token start on skip or delimiter byte");

  // A stalled full output blocks input next cycle
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_chan.ready) |=> skid_valid_r)
    else $error("skid entry lost while output stalled");

endmodule

/* hdl/hrbp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbp_core
// Parser state registers and the one-byte state step. Advances on step_en and
// presents the result of that byte combinationally.
// ----------------------------------------------------------------------------
module hrbp_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    data_byte,
  input  logic          first_byte,
  input  logic          last_byte,
  output hrbp_pkg::res_t res
);
  import hrbp_pkg::*;

  parse_state_t         state_r, state_nxt;
  logic [3:0]           kpos_r, kpos_nxt;
  logic                 kis_r, kis_nxt;
  logic                 has_r, has_nxt;
  logic [LenBits-1:0]   acc_r, acc_nxt;
  logic [LenBits-1:0]   left_r, left_nxt;

  // State as seen by this byte (a first byte starts from reset values)
  parse_state_t         s_cur;
  logic [3:0]           kpos_cur;
  logic                 kis_cur, has_cur;
  logic [LenBits-1:0]   acc_cur, left_cur;

  logic [LenBits+3:0]   acc_x10;
  logic [LenBits-1:0]   left_dec;
  logic                 key_hit;
  field_tag_t           tag;
  logic                 start;
  logic [7:0]           c;

  assign c        = data_byte;
  assign s_cur    = first_byte ? S_START : state_r;
  assign kpos_cur = first_byte ? 4'd0 : kpos_r;
  assign kis_cur  = first_byte ? 1'b0 : kis_r;
  assign has_cur  = first_byte ? 1'b0 : has_r;
  assign acc_cur  = first_byte ? '0 : acc_r;
  assign left_cur = first_byte ? '0 : left_r;

  // Decimal accumulate: acc*10 + digit; any carry out means saturation
  assign acc_x10 = {acc_cur, 3'b000} + {2'b00, acc_cur, 1'b0}
                 + {(LenBits)'(0), 4'(c - ChZero)};
  assign left_dec = (left_cur != '0) ? left_cur - 1'b1 : left_cur;
  assign key_hit  = (kpos_cur < 4'(KeyLen)) && (c == key_char(kpos_cur));

  // Next state and field classification for one byte
  always_comb begin
    state_nxt = s_cur;
    kpos_nxt  = kpos_cur;
    kis_nxt   = kis_cur;
    has_nxt   = has_cur;
    acc_nxt   = acc_cur;
    left_nxt  = left_cur;
    tag       = TAG_SKIP;
    start     = 1'b0;
    case (s_cur)
      S_START: begin
        if (c == ChCr || c == ChLf || is_blank(c)) begin
          tag = TAG_SKIP;
        end else if (is_upper(c)) begin
          tag = TAG_METHOD; start = 1'b1; state_nxt = S_METHOD;
        end else begin
          state_nxt = S_INVALID;
        end
      end
      S_METHOD: begin
        if (is_upper(c)) tag = TAG_METHOD;
        else if (is_blank(c)) begin
          tag = TAG_DELIM; state_nxt = S_BEFORE_URI;
        end else state_nxt = S_BAD_METHOD;
      end
      S_BEFORE_URI: begin
        if (is_blank(c)) tag = TAG_DELIM;
        else if (c == ChSlash) begin
          tag = TAG_PATH; start = 1'b1; state_nxt = S_URI;
        end else state_nxt = S_BAD_URI;
      end
      S_URI: begin
        if (is_blank(c)) begin
          tag = TAG_DELIM; state_nxt = S_BEFORE_PROTO;
        end else if (c == ChQuest) begin
          tag = TAG_DELIM; state_nxt = S_BEFORE_PKEY;
        end else tag = TAG_PATH;
      end
      S_BEFORE_PKEY: begin
        if (is_blank(c) || c == ChCr || c == ChLf) state_nxt = S_BAD_URI;
        else begin
          tag = TAG_PKEY; start = 1'b1; state_nxt = S_PKEY;
        end
      end
      S_PKEY: begin
        if (is_blank(c)) state_nxt = S_BAD_URI;
        else if (c == ChEqual) begin
          tag = TAG_DELIM; state_nxt = S_BEFORE_PVAL;
        end else tag = TAG_PKEY;
      end
      S_BEFORE_PVAL: begin
        if (is_blank(c) || c == ChCr || c == ChLf) state_nxt = S_BAD_URI;
        else begin
          tag = TAG_PVAL; start = 1'b1; state_nxt = S_PVAL;
        end
      end
      S_PVAL: begin
        if (c == ChAmp) begin
          tag = TAG_DELIM; state_nxt = S_BEFORE_PKEY;
        end else if (is_blank(c)) begin
          tag = TAG_DELIM; state_nxt = S_BEFORE_PROTO;
        end else tag = TAG_PVAL;
      end
      S_BEFORE_PROTO: begin
        if (is_blank(c)) tag = TAG_DELIM;
        else begin
          tag = TAG_PROTO; start = 1'b1; state_nxt = S_PROTO;
        end
      end
      S_PROTO: begin
        if (c == ChSlash) begin
          tag = TAG_DELIM; state_nxt = S_BEFORE_VER;
        end else tag = TAG_PROTO;
      end
      S_BEFORE_VER: begin
        if (is_digit(c)) begin
          tag = TAG_VERSION; start = 1'b1; state_nxt = S_VER;
        end else state_nxt = S_BAD_VERSION;
      end
      S_VER: begin
        if (c == ChDot) begin
          tag = TAG_VERSION; state_nxt = S_VER_SPLIT;
        end else if (c == ChCr) begin
          tag = TAG_DELIM; state_nxt = S_WHEN_CR;
        end else if (is_digit(c)) tag = TAG_VERSION;
        else state_nxt = S_INVALID;
      end
      S_VER_SPLIT: begin
        if (is_digit(c)) begin
          tag = TAG_VERSION; state_nxt = S_VER;
        end else state_nxt = S_BAD_VERSION;
      end
      S_WHEN_CR: begin
        if (c == ChLf) begin
          tag = TAG_DELIM; state_nxt = S_CR_LF;
        end else state_nxt = S_INVALID;
      end
      S_CR_LF: begin
        if (c == ChCr) begin
          tag = TAG_DELIM; state_nxt = S_CR_LF_CR;
        end else if (is_blank(c)) state_nxt = S_INVALID;
        else begin
          // Begin a header key; start matching Content-Length
          tag = TAG_HKEY; start = 1'b1; state_nxt = S_HKEY;
          kis_nxt  = (c == key_char(4'd0));
          kpos_nxt = (c == key_char(4'd0)) ? 4'd1 : 4'd0;
        end
      end
      S_HKEY: begin
        if (is_blank(c) || c == ChColon) begin
          tag = TAG_DELIM;
          state_nxt = is_blank(c) ? S_HBEFORE_COLON : S_HAFTER_COLON;
          kis_nxt = kis_cur && (kpos_cur == 4'(KeyLen));
          if (kis_cur && (kpos_cur == 4'(KeyLen))) begin
            has_nxt = 1'b1;
            acc_nxt = '0;
          end
        end else begin
          tag = TAG_HKEY;
          if (kis_cur && key_hit) kpos_nxt = kpos_cur + 4'd1;
          else kis_nxt = 1'b0;
        end
      end
      S_HBEFORE_COLON: begin
        if (is_blank(c)) tag = TAG_DELIM;
        else if (c == ChColon) begin
          tag = TAG_DELIM; state_nxt = S_HAFTER_COLON;
        end else state_nxt = S_BAD_HEADER;
      end
      S_HAFTER_COLON, S_HVAL: begin
        if (s_cur == S_HAFTER_COLON && is_blank(c)) begin
          tag = TAG_DELIM;
        end else if (s_cur == S_HVAL && c == ChCr) begin
          tag = TAG_DELIM; state_nxt = S_WHEN_CR; kis_nxt = 1'b0;
        end else begin
          tag = TAG_HVAL;
          if (s_cur == S_HAFTER_COLON) begin
            start = 1'b1; state_nxt = S_HVAL;
          end
          // Accumulate Content-Length digits, saturating
          if (kis_cur) begin
            if (is_digit(c)) begin
              if (acc_x10[LenBits+3:LenBits] != 4'd0) acc_nxt = '1;
              else acc_nxt = acc_x10[LenBits-1:0];
            end else kis_nxt = 1'b0;
          end
        end
      end
      S_CR_LF_CR: begin
        if (c == ChLf) begin
          tag = TAG_DELIM;
          if (has_cur && acc_cur != '0) begin
            left_nxt = acc_cur; state_nxt = S_BODY;
          end else state_nxt = S_COMPLETE;
        end else state_nxt = S_BAD_HEADER;
      end
      S_BODY: begin
        // Count the body out one byte at a time
        tag      = TAG_BODY;
        start    = (left_cur == acc_cur);
        left_nxt = left_dec;
        if (left_dec == '0) state_nxt = S_COMPLETE;
      end
      default: begin
        tag = TAG_SKIP;
      end
    endcase
  end

  // Result of this byte
  always_comb begin
    res.byte_out       = c;
    res.field_tag      = tag;
    res.token_start    = start;
    res.status         = status_of(state_nxt);
    res.content_length = 32'(acc_nxt);
    res.done_res       = (status_of(state_nxt) != ST_PARSING) || last_byte;
  end

  // Hold parser state; advance on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      kpos_r  <= 4'd0;
      kis_r   <= 1'b0;
      has_r   <= 1'b0;
      acc_r   <= '0;
      left_r  <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      kpos_r  <= kpos_nxt;
      kis_r   <= kis_nxt;
      has_r   <= has_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

/* verif/tb_http_request_byte_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_byte_parser
// Self-checking bench for the byte-serial HTTP request parser. Every byte
// taken by the parser is run through a behavioral parser in the bench, and
// each tagged byte that comes out is compared field by field with it.
// Directed requests cover every field, separator and error kind; random
// requests with random content, mutations and noise follow, with random
// gaps on the input side, random stalls on the output side and one long
// output hold-off that fills the parser and stalls its input.
// ----------------------------------------------------------------------------
module tb_http_request_byte_parser;
  import hrbp_pkg::*;

  // "Content-Length", first character in the top byte
  localparam logic [8*KeyLen-1:0] LenKeyText = "Content-Length";
  localparam int BigLen = 1000;
  // Random traffic stops once this many bytes have been offered over the run
  localparam int ItemGoal = 1200;

  logic clk;
  logic rst_n;

  hrbp_in_if  req_if ();
  hrbp_out_if res_if ();

  http_request_byte_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  // Behavioral parser state
  parse_state_t ps;
  logic [3:0]   kpos;
  logic         kmatch;
  logic         seen_len;
  logic [31:0]  len_acc;
  logic [31:0]  body_cnt;

  res_t       pending_results[$];
  logic [7:0] req_bytes[$];

  int fail_cnt;
  int results_checked;
  int live_bytes;
  int items_sent;
  int requests_sent;
  int final_hits[8];
  int hold_off;
  int burst_left;
  bit no_gaps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the tagged byte for one accepted request and advance the state
  function automatic res_t parse_byte(input logic [7:0] c, input logic fb,
                                      input logic lb);
    parse_state_t nxt;
    field_tag_t   tg;
    status_t      st;
    logic         ts;
    logic         blank;
    logic         digit;
    logic         upper;
    logic         eol_ch;
    logic [63:0]  grown;
    res_t         r;
    blank  = (c == ChSpace) || (c == ChTab);
    digit  = (c >= ChZero) && (c <= ChNine);
    upper  = (c >= ChUpA) && (c <= ChUpZ);
    eol_ch = (c == ChCr) || (c == ChLf);
    if (fb) begin
      ps       = S_START;
      kpos     = '0;
      kmatch   = 1'b0;
      seen_len = 1'b0;
      len_acc  = '0;
      body_cnt = '0;
    end
    nxt = ps;
    tg  = TAG_SKIP;
    ts  = 1'b0;
    if (ps < S_COMPLETE) live_bytes++;
    case (ps)
      S_START: begin
        if (upper) begin
          tg = TAG_METHOD; ts = 1'b1; nxt = S_METHOD;
        end else if (!(eol_ch || blank)) begin
          nxt = S_INVALID;
        end
      end
      S_METHOD: begin
        if (upper) tg = TAG_METHOD;
        else if (blank) begin
          tg = TAG_DELIM; nxt = S_BEFORE_URI;
        end else nxt = S_BAD_METHOD;
      end
      S_BEFORE_URI: begin
        if (blank) tg = TAG_DELIM;
        else if (c == ChSlash) begin
          tg = TAG_PATH; ts = 1'b1; nxt = S_URI;
        end else nxt = S_BAD_URI;
      end
      S_URI: begin
        if (blank) begin
          tg = TAG_DELIM; nxt = S_BEFORE_PROTO;
        end else if (c == ChQuest) begin
          tg = TAG_DELIM; nxt = S_BEFORE_PKEY;
        end else tg = TAG_PATH;
      end
      S_BEFORE_PKEY: begin
        if (blank || eol_ch) nxt = S_BAD_URI;
        else begin
          tg = TAG_PKEY; ts = 1'b1; nxt = S_PKEY;
        end
      end
      S_PKEY: begin
        if (blank) nxt = S_BAD_URI;
        else if (c == ChEqual) begin
          tg = TAG_DELIM; nxt = S_BEFORE_PVAL;
        end else tg = TAG_PKEY;
      end
      S_BEFORE_PVAL: begin
        if (blank || eol_ch) nxt = S_BAD_URI;
        else begin
          tg = TAG_PVAL; ts = 1'b1; nxt = S_PVAL;
        end
      end
      S_PVAL: begin
        if (c == ChAmp) begin
          tg = TAG_DELIM; nxt = S_BEFORE_PKEY;
        end else if (blank) begin
          tg = TAG_DELIM; nxt = S_BEFORE_PROTO;
        end else tg = TAG_PVAL;
      end
      S_BEFORE_PROTO: begin
        if (blank) tg = TAG_DELIM;
        else begin
          tg = TAG_PROTO; ts = 1'b1; nxt = S_PROTO;
        end
      end
      S_PROTO: begin
        if (c == ChSlash) begin
          tg = TAG_DELIM; nxt = S_BEFORE_VER;
        end else tg = TAG_PROTO;
      end
      S_BEFORE_VER: begin
        if (digit) begin
          tg = TAG_VERSION; ts = 1'b1; nxt = S_VER;
        end else nxt = S_BAD_VERSION;
      end
      S_VER: begin
        if (c == ChDot) begin
          tg = TAG_VERSION; nxt = S_VER_SPLIT;
        end else if (c == ChCr) begin
          tg = TAG_DELIM; nxt = S_WHEN_CR;
        end else if (digit) tg = TAG_VERSION;
        else nxt = S_INVALID;
      end
      S_VER_SPLIT: begin
        if (digit) begin
          tg = TAG_VERSION; nxt = S_VER;
        end else nxt = S_BAD_VERSION;
      end
      S_WHEN_CR: begin
        if (c == ChLf) begin
          tg = TAG_DELIM; nxt = S_CR_LF;
        end else nxt = S_INVALID;
      end
      S_CR_LF: begin
        if (c == ChCr) begin
          tg = TAG_DELIM; nxt = S_CR_LF_CR;
        end else if (blank) nxt = S_INVALID;
        else begin
          tg     = TAG_HKEY;
          ts     = 1'b1;
          nxt    = S_HKEY;
          kmatch = (c == LenKeyText[8*(KeyLen-1) +: 8]);
          kpos   = kmatch ? 4'd1 : 4'd0;
        end
      end
      S_HKEY: begin
        if (blank || c == ChColon) begin
          tg     = TAG_DELIM;
          nxt    = blank ? S_HBEFORE_COLON : S_HAFTER_COLON;
          kmatch = kmatch && (kpos == KeyLen);
          if (kmatch) begin
            seen_len = 1'b1;
            len_acc  = '0;
          end
        end else begin
          tg = TAG_HKEY;
          if (kmatch && kpos < KeyLen && c == LenKeyText[8*(KeyLen-1-kpos) +: 8]) kpos++;
          else kmatch = 1'b0;
        end
      end
      S_HBEFORE_COLON: begin
        if (blank) tg = TAG_DELIM;
        else if (c == ChColon) begin
          tg = TAG_DELIM; nxt = S_HAFTER_COLON;
        end else nxt = S_BAD_HEADER;
      end
      S_HAFTER_COLON, S_HVAL: begin
        if (ps == S_HAFTER_COLON && blank) begin
          tg = TAG_DELIM;
        end else if (ps == S_HVAL && c == ChCr) begin
          tg = TAG_DELIM; nxt = S_WHEN_CR; kmatch = 1'b0;
        end else begin
          tg = TAG_HVAL;
          if (ps == S_HAFTER_COLON) begin
            ts = 1'b1; nxt = S_HVAL;
          end
          // accumulate decimal digits, saturate at all ones
          if (kmatch) begin
            if (digit) begin
              grown = {32'd0, len_acc} * 64'd10 + {56'd0, (c - ChZero)};
              len_acc = (grown > 64'h0000_0000_FFFF_FFFF) ? '1 : grown[31:0];
            end else kmatch = 1'b0;
          end
        end
      end
      S_CR_LF_CR: begin
        if (c == ChLf) begin
          tg = TAG_DELIM;
          if (seen_len && len_acc != 0) begin
            body_cnt = len_acc; nxt = S_BODY;
          end else nxt = S_COMPLETE;
        end else nxt = S_BAD_HEADER;
      end
      S_BODY: begin
        tg = TAG_BODY;
        ts = (body_cnt == len_acc);
        if (body_cnt != 0) body_cnt--;
        if (body_cnt == 0) nxt = S_COMPLETE;
      end
      default: ;
    endcase
    case (nxt)
      S_COMPLETE:    st = ST_COMPLETE;
      S_INVALID:     st = ST_INVALID;
      S_BAD_METHOD:  st = ST_BAD_METHOD;
      S_BAD_URI:     st = ST_BAD_URI;
      S_BAD_VERSION: st = ST_BAD_VERSION;
      S_BAD_HEADER:  st = ST_BAD_HEADER;
      default:       st = ST_PARSING;
    endcase
    if (ps < S_COMPLETE && st != ST_PARSING) final_hits[st]++;
    ps = nxt;
    r.byte_out       = c;
    r.field_tag      = tg;
    r.token_start    = ts;
    r.status         = st;
    r.content_length = len_acc;
    r.done_res       = (st != ST_PARSING) || lb;
    return r;
  endfunction

  // Compare one result with the oldest expected one
  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("ERROR: unexpected result byte=%02h tag=%0d status=%0d",
                 res_if.byte_out, res_if.field_tag, res_if.status);
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      if (res_if.byte_out !== want.byte_out || res_if.field_tag !== want.field_tag ||
          res_if.token_start !== want.token_start || res_if.status !== want.status ||
          res_if.content_length !== want.content_length ||
          res_if.done_res !== want.done_res) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("ERROR: result %0d expected byte=%02h tag=%0d start=%0b status=%0d len=%0d done=%0b",
                   results_checked, want.byte_out, want.field_tag, want.token_start,
                   want.status, want.content_length, want.done_res);
          $display("       actual          byte=%02h tag=%0d start=%0b status=%0d len=%0d done=%0b",
                   res_if.byte_out, res_if.field_tag, res_if.token_start, res_if.status,
                   res_if.content_length, res_if.done_res);
        end
      end
    end
  endtask

  // Check results, then predict for the request taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) check_result();
      if (req_if.valid && req_if.ready)
        pending_results.push_back(parse_byte(req_if.data_byte, req_if.first_byte,
                                             req_if.last_byte));
    end
  end

  // Output side: stall in phases of random density, or hold off on request
  initial begin : result_sink
    int phase_left;
    int stall_pct;
    res_if.ready = 1'b0;
    phase_left   = 0;
    stall_pct    = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        res_if.ready <= 1'b0;
        hold_off--;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        phase_left--;
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one byte, in bursts with random gaps, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fb, input logic lb);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    req_if.valid      <= 1'b1;
    req_if.data_byte  <= b;
    req_if.first_byte <= fb;
    req_if.last_byte  <= lb;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid after the last taken byte
  task automatic idle_bus();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  // Pause the input until every expected result has come out
  task automatic wait_drain();
    idle_bus();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    req_bytes.push_back(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  task automatic push_eol();
    push_byte(ChCr);
    push_byte(ChLf);
  endtask

  task automatic push_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) push_byte($urandom_range(0, 1) ? ChSpace : ChTab);
  endtask

  function automatic logic [7:0] token_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(ChUpA, ChUpZ));
      1:       return 8'($urandom_range(8'h61, 8'h7A)); // lower case
      2:       return 8'($urandom_range(ChZero, ChNine));
      default: return 8'h2D; // dash
    endcase
  endfunction

  // Any byte that stays inside a path: no blank, no query mark
  function automatic logic [7:0] path_char();
    logic [7:0] b;
    b = 8'($urandom_range(8'h21, 8'hFF));
    return (b == ChQuest) ? ChSlash : b;
  endfunction

  // Send the queued bytes as one request, then clear the queue
  task automatic send_request(input logic fb, input logic lb_end, input int split_pct);
    int   n;
    logic lb;
    n = req_bytes.size();
    for (int i = 0; i < n; i++) begin
      lb = ((i == n - 1) && lb_end) || ($urandom_range(0, 99) < split_pct);
      send_byte(req_bytes[i], fb && (i == 0), lb);
    end
    req_bytes.delete();
    requests_sent++;
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_request(1'b1, 1'b1, 0);
  endtask

  // Queue a well-formed request with random content and a body sized from its Content-Length
  task automatic build_request();
    int kind;
    int n;
    int cl_val;
    cl_val = 0;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       push_byte(ChCr);
        1:       push_byte(ChLf);
        2:       push_byte(ChSpace);
        default: push_byte(ChTab);
      endcase
    end
    repeat ($urandom_range(1, 7)) push_byte(8'($urandom_range(ChUpA, ChUpZ)));
    push_blanks(1, 2);
    push_byte(ChSlash);
    repeat ($urandom_range(0, 6)) push_byte(path_char());
    if ($urandom_range(0, 2) == 0) begin
      push_byte(ChQuest);
      n = $urandom_range(1, 3);
      for (int p = 0; p < n; p++) begin
        if (p > 0) push_byte(ChAmp);
        repeat ($urandom_range(1, 4)) push_byte(token_char());
        push_byte(ChEqual);
        repeat ($urandom_range(1, 4)) push_byte(token_char());
      end
    end
    push_blanks(1, 2);
    if ($urandom_range(0, 1)) push_text("HTTP");
    else repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(ChUpA, ChUpZ)));
    push_byte(ChSlash);
    repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(ChZero, ChNine)));
    if ($urandom_range(0, 1)) begin
      push_byte(ChDot);
      repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(ChZero, ChNine)));
    end
    push_eol();
    // header lines, Content-Length and near misses most of the time
    repeat ($urandom_range(0, 3)) begin
      kind = $urandom_range(0, 7);
      case (kind)
        0, 1, 2: push_text("Content-Length");
        3:       push_text("content-length");
        4:       push_text("Content-Len");
        5:       push_text("Content-Lengths");
        default: repeat ($urandom_range(1, 8)) push_byte(token_char());
      endcase
      if ($urandom_range(0, 3) == 0) push_blanks(1, 2);
      push_byte(ChColon);
      push_blanks(0, 2);
      if (kind <= 2) begin
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            n = $urandom_range(0, 24);
            push_text($sformatf("%0d", n));
            cl_val = n;
          end
          3: begin
            n = $urandom_range(1, 9);
            push_text($sformatf("%0dx1", n));
            cl_val = n;
          end
          4: begin
            push_text("abc");
            cl_val = 0;
          end
          default: begin
            repeat ($urandom_range(10, 14)) push_byte(8'($urandom_range(ChZero, ChNine)));
            cl_val = BigLen;
          end
        endcase
      end else begin
        push_byte(8'($urandom_range(8'h21, 8'hFF)));
        repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(8'h20, 8'hFF)));
      end
      push_eol();
    end
    push_eol();
    // body; a long one is cut short and the next request restarts
    n = (cl_val > 24) ? $urandom_range(0, 24) : cl_val;
    if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Every error kind, leading whitespace, a non-ASCII start, ignored tails
  task automatic test_malformed_lines();
    push_byte(ChCr);
    push_byte(ChLf);
    push_text(" \tx");
    push_text("Qz");
    send_request(1'b1, 1'b1, 0);
    push_byte(8'hFF);
    send_request(1'b1, 1'b0, 0);
    send_text("G1");
    send_text("GET x");
    send_text("G /? ");
    send_text("G /?k ");
    send_text("G /?k= ");
    send_text("G / H/x");
    send_text("G / H/1.x");
    send_text("G / H/1x");
    push_text("G / H/1");
    push_byte(ChCr);
    push_text("x");
    send_request(1'b1, 1'b1, 0);
    push_text("G / H/1");
    push_eol();
    push_text(" ");
    send_request(1'b1, 1'b1, 0);
    push_text("G / H/1");
    push_eol();
    push_byte(ChCr);
    push_text("x");
    send_request(1'b1, 1'b1, 0);
    push_text("G / H/1");
    push_eol();
    push_text("K x");
    send_request(1'b1, 1'b1, 0);
  endtask

  // Full request lines with query parameters, tabs and trailing bytes
  task automatic test_request_line();
    push_text("GET /a/b?k=v&x=y HTTP/1.1");
    push_eol();
    push_text("Host: h");
    push_eol();
    push_eol();
    push_text("zz");
    send_request(1'b1, 1'b1, 0);
    push_text("PUT\t\t/ \tH/12");
    push_eol();
    push_eol();
    send_request(1'b1, 1'b1, 0);
  endtask

  // Content-Length: plain, saturating, no digit, digits then junk, repeated,
  // zero and near-miss keys
  task automatic test_content_length();
    push_text("POST /u H/1.0");
    push_eol();
    push_text("Content-Length: 3");
    push_eol();
    push_eol();
    push_text("abcd");
    send_request(1'b1, 1'b1, 0);
    push_text("P / H/1");
    push_eol();
    push_text("Content-Length : 99999999999");
    push_eol();
    push_eol();
    push_text("body");
    send_request(1'b1, 1'b0, 0);
    push_text("P / H/1");
    push_eol();
    push_text("Content-Length:x5");
    push_eol();
    push_eol();
    send_request(1'b1, 1'b1, 0);
    push_text("P / H/1");
    push_eol();
    push_text("Content-Length: 12ab");
    push_eol();
    push_text("content-length: 3");
    push_eol();
    push_text("Content-Length:2");
    push_eol();
    push_eol();
    push_text("xy");
    send_request(1'b1, 1'b1, 0);
    push_text("P / H/1");
    push_eol();
    push_text("Content-Length: 0");
    push_eol();
    push_eol();
    send_request(1'b1, 1'b1, 0);
    push_text("P / H/1");
    push_eol();
    push_text("Content-Lengthy: 5");
    push_eol();
    push_eol();
    send_request(1'b1, 1'b1, 0);
  endtask

  // Request split over two buffers, then a byte ignored after completion
  task automatic test_split_buffers();
    push_text("GET /p H");
    send_request(1'b1, 1'b1, 0);
    push_text("TTP/1.1");
    push_eol();
    push_eol();
    send_request(1'b0, 1'b1, 0);
    push_text("A");
    send_request(1'b0, 1'b0, 0);
  endtask

  // Long output hold-off with the input streaming, then a mid-request drain
  task automatic test_backpressure();
    idle_bus();
    @(posedge clk);
    hold_off = 60;
    no_gaps  = 1'b1;
    push_text("POST /up HTTP/1.1");
    push_eol();
    push_text("Content-Length: 20");
    push_eol();
    push_eol();
    repeat (20) push_byte(8'($urandom_range(0, 255)));
    send_request(1'b1, 1'b1, 0);
    no_gaps = 1'b0;
    push_text("GET /x?a=1 HTTP/1.1");
    send_request(1'b1, 1'b0, 0);
    wait_drain();
    push_eol();
    push_eol();
    send_request(1'b0, 1'b1, 0);
  endtask

  // Random requests, mutated and cut short at times, mixed with noise
  task automatic test_random_traffic();
    int n;
    while (items_sent < ItemGoal) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) == 0);
      end else begin
        build_request();
        if ($urandom_range(0, 5) == 0)
          req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) begin
          n = $urandom_range(1, req_bytes.size());
          while (req_bytes.size() > n) void'(req_bytes.pop_back());
        end
        send_request($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), 5);
      end
      if ($urandom_range(0, 15) == 0) wait_drain();
    end
  endtask

  initial begin : main
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.data_byte  = '0;
    req_if.first_byte = 1'b0;
    req_if.last_byte  = 1'b0;
    fail_cnt          = 0;
    results_checked   = 0;
    live_bytes        = 0;
    items_sent        = 0;
    requests_sent     = 0;
    hold_off          = 0;
    burst_left        = 0;
    no_gaps           = 1'b0;
    for (int i = 0; i < 8; i++) final_hits[i] = 0;
    ps       = S_START;
    kpos     = '0;
    kmatch   = 1'b0;
    seen_len = 1'b0;
    len_acc  = '0;
    body_cnt = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_malformed_lines();
    test_request_line();
    test_content_length();
    test_split_buffers();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests, %0d bytes checked, %0d bytes parsed before a final status",
             requests_sent, results_checked, live_bytes);
    $display("Final statuses: complete %0d invalid %0d method %0d uri %0d version %0d header %0d",
             final_hits[ST_COMPLETE], final_hits[ST_INVALID], final_hits[ST_BAD_METHOD],
             final_hits[ST_BAD_URI], final_hits[ST_BAD_VERSION], final_hits[ST_BAD_HEADER]);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(5_000_000);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
